[src/pcbp_pkg.sv]
// ============================================================================
// pcbp_pkg
// Shared types and constants for the prefix code bit packer.
// ============================================================================
package pcbp_pkg;

  // Default configuration
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int SYMBOL_COUNT_DEF  = 256;

  // Command opcodes (code 3 is unused and ignored)
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  // Input transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic [5:0]  code_length;
    logic [31:0] code_value;
  } cmd_item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] packed_byte;
    logic [2:0] pad_count;
    logic       final_byte;
  } res_item_t;

  // Merge request from the table stage to the packer
  typedef struct packed {
    logic encode;
    logic flush;
  } merge_t;

endpackage

[src/pcbp_packer.sv]
// ============================================================================
// pcbp_packer
// Left-aligned bit accumulator that takes one code per merge and drains
// whole bytes into the output register, one per cycle unless it stalls.
// ============================================================================
module pcbp_packer #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS_DEF,
  localparam int CodeW = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32,
  localparam int LenW  = $clog2(CodeW + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  pcbp_pkg::merge_t    merge,
  input  logic [LenW-1:0]     code_len,
  input  logic [CodeW-1:0]    code_bits,
  output logic                merge_ok,
  output logic                res_valid,
  input  logic                res_ready,
  output pcbp_pkg::res_item_t res
);

  localparam int AccW = CodeW + 7;
  localparam int CntW = $clog2(AccW + 1);

  logic [AccW-1:0]  acc;
  logic [CntW-1:0]  cnt;
  logic [2:0]       pad;

  logic             has_byte;
  logic             emit;
  logic [LenW-1:0]  align_shamt;
  logic [CodeW-1:0] code_la;
  logic [AccW-1:0]  code_ext;
  logic [CntW-1:0]  cnt_after;

  // Byte availability and output handshake
  assign has_byte = cnt >= CntW'(8);
  assign merge_ok = !has_byte;
  assign emit     = has_byte && (!res_valid || res_ready);
  assign cnt_after = cnt - CntW'(8);

  // Left-align the code (bits above the length fall off), then place it
  // right after the pending bits
  assign align_shamt = LenW'(CodeW) - code_len;
  assign code_la     = code_bits << align_shamt;
  assign code_ext    = {code_la, 7'b0} >> cnt[2:0];

  // Accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      pad <= '0;
    end else if (emit) begin
      acc <= acc << 8;
      cnt <= cnt_after;
    end else if (merge.encode) begin
      acc <= acc | code_ext;
      cnt <= cnt + CntW'(code_len);
      pad <= '0;
    end else if (merge.flush && (cnt != '0)) begin
      // low bits are already zero, so the partial byte is padded as is
      cnt <= CntW'(8);
      pad <= 3'(~cnt[2:0] + 3'd1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.packed_byte <= acc[AccW-1 -: 8];
      res.pad_count   <= pad;
      res.final_byte  <= cnt_after < CntW'(8);
    end
  end

endmodule

[src/prefix_code_bit_packer_unit.sv]
// ============================================================================
// prefix_code_bit_packer_unit
// Prefix code encoder: code table load, symbol encode and final-byte flush.
// ============================================================================
// The code table is loaded first with one load transaction per symbol; after
// that each encode transaction appends the symbol's code, first bit first,
// and every complete byte comes out with its earliest bit in bit 7. A flush
// zero-pads the last partial byte and reports the pad count. The table sits
// in a synchronous memory read once per command; a load writes at the edge
// it is accepted, so an encode right behind it sees the new entry. A command
// that yields output bytes occupies the packer for one merge, then drains
// one byte per cycle into the output register while it is not stalled; an
// encode yields at most four bytes. Back-to-back loads go at one per cycle,
// and zero-length codes and empty flushes too while the packer holds no
// complete byte. A byte passes the table read, accumulator and output register.
// ============================================================================
module prefix_code_bit_packer_unit #(
  parameter int MAX_CODE_BITS = pcbp_pkg::MAX_CODE_BITS_DEF,
  parameter int SYMBOL_COUNT  = pcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pcbp_pkg::cmd_item_t cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output pcbp_pkg::res_item_t res
);

  localparam int CodeW = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam int LenW  = $clog2(CodeW + 1);
  localparam int SymW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int EntW  = LenW + CodeW;

  // Code table: {length, code}
  logic [EntW-1:0]  code_mem [SYMBOL_COUNT];
  logic [EntW-1:0]  rd_entry;

  logic             accept;
  logic             sym_ok;
  logic [SymW-1:0]  addr;
  logic [LenW-1:0]  sat_len;

  logic             s1_valid;
  logic [1:0]       s1_op;
  logic             s1_ok;
  logic             s1_needs;
  logic             s1_done;

  pcbp_pkg::merge_t merge;
  logic             merge_ok;

  // Command decode
  assign accept  = cmd_valid && cmd_ready;
  assign sym_ok  = {1'b0, cmd.symbol} < 9'(SYMBOL_COUNT);
  assign addr    = cmd.symbol[SymW-1:0];
  assign sat_len = (cmd.code_length > 6'(CodeW)) ? LenW'(CodeW)
                                                 : cmd.code_length[LenW-1:0];

  // Table memory: write on load, read on every accepted command
  always_ff @(posedge clk) begin
    if (accept && (cmd.op == pcbp_pkg::OP_LOAD) && sym_ok) begin
      code_mem[addr] <= {sat_len, cmd.code_value[CodeW-1:0]};
    end
    if (accept) begin
      rd_entry <= code_mem[addr];
    end
  end

  // Table-read stage; flushes and in-range encodes wait until the packer holds no complete byte
  assign s1_needs = s1_valid &&
                    (((s1_op == pcbp_pkg::OP_ENCODE) && s1_ok) ||
                     (s1_op == pcbp_pkg::OP_FLUSH));
  assign s1_done   = !s1_needs || merge_ok;
  assign cmd_ready = !s1_valid || s1_done;

  assign merge.encode = s1_valid && (s1_op == pcbp_pkg::OP_ENCODE) && s1_ok && merge_ok;
  assign merge.flush  = s1_valid && (s1_op == pcbp_pkg::OP_FLUSH) && merge_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= cmd.op;
      s1_ok <= sym_ok;
    end
  end

  // Bit accumulator and output register
  pcbp_packer #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .merge     (merge),
    .code_len  (rd_entry[EntW-1 -: LenW]),
    .code_bits (rd_entry[CodeW-1:0]),
    .merge_ok  (merge_ok),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[src/pcbp_checker.sv]
// ============================================================================
// pcbp_checker
// Port-level checks for the prefix code bit packer, bound to the top level.
// ============================================================================
module pcbp_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input pcbp_pkg::cmd_item_t cmd,
  input logic                res_valid,
  input logic                res_ready,
  input pcbp_pkg::res_item_t res
);

  // No result may be offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  // A stalled result holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Padding only appears on the closing byte of a flush
  a_pad_final: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.pad_count == 3'd0) || res.final_byte)
    else $error("padded byte not marked final");

  // The padded low bits of a flush byte are all zero
  a_pad_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.pad_count != 3'd0) |-> res.pad_count != 3'd0 &&
    ((res.packed_byte & 8'(8'hFF >> (4'd8 - {1'b0, res.pad_count}))) == 8'd0))
    else $error("pad bits not zero");

endmodule

bind prefix_code_bit_packer_unit pcbp_checker u_pcbp_checker (.*);

[test/packed_byte_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// packed_byte_checker
// Watches both channels of the prefix code bit packer. It keeps its own copy
// of the code table and the leftover bits, works out the bytes each command
// transaction should produce, and compares every result transaction with the
// oldest byte still expected. The failure count and the number of bytes still
// expected go back to the testbench top.
// ============================================================================
module packed_byte_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_ready,
  input  pcbp_pkg::cmd_item_t cmd,
  input  logic                res_valid,
  input  logic                res_ready,
  input  pcbp_pkg::res_item_t res,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int REPORT_LIMIT = 10;
  // A loaded length saturates at the configured maximum, and never above 32
  localparam int CODE_CAP     = (pcbp_pkg::MAX_CODE_BITS_DEF < 32) ?
                                pcbp_pkg::MAX_CODE_BITS_DEF : 32;

  // Shadow code table and leftover bit accumulator
  logic [5:0]          shadow_len  [256];
  logic [31:0]         shadow_code [256];
  logic [6:0]          leftover_bits;
  logic [2:0]          leftover_count;
  pcbp_pkg::res_item_t expected_bytes [$];

  // Append the bytes that one command transaction produces
  task automatic pack_code_bytes(input pcbp_pkg::cmd_item_t c);
    logic [5:0]          len;
    logic [63:0]         code;
    logic [63:0]         acc;
    logic [7:0]          pad_byte;
    logic [2:0]          pad;
    int                  total;
    int                  nbytes;
    pcbp_pkg::res_item_t r;
    case (pcbp_pkg::op_t'(c.op))
      pcbp_pkg::OP_LOAD: begin
        len = (c.code_length > CODE_CAP) ? 6'(CODE_CAP) : c.code_length;
        shadow_len[c.symbol]  = len;
        shadow_code[c.symbol] = c.code_value;
      end
      pcbp_pkg::OP_ENCODE: begin
        len = shadow_len[c.symbol];
        if (len != 0) begin
          code = {32'd0, shadow_code[c.symbol]};
          if (len < 32) code &= (64'd1 << len) - 64'd1;
          acc    = ({57'd0, leftover_bits} << len) | code;
          total  = leftover_count + len;
          nbytes = total / 8;
          for (int k = 0; k < nbytes; k++) begin
            total         -= 8;
            r.packed_byte  = acc[total +: 8];
            r.pad_count    = 3'd0;
            r.final_byte   = (k == nbytes - 1);
            expected_bytes.push_back(r);
          end
          leftover_count = total[2:0];
          leftover_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
        end
      end
      pcbp_pkg::OP_FLUSH: begin
        // Nothing pending means no byte and no pad
        if (leftover_count != 0) begin
          pad      = 3'(8 - leftover_count);
          pad_byte = {1'b0, leftover_bits} << pad;
          r.packed_byte = pad_byte;
          r.pad_count   = pad;
          r.final_byte  = 1'b1;
          expected_bytes.push_back(r);
          leftover_bits  = '0;
          leftover_count = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_failure(input string what, input pcbp_pkg::res_item_t exp_item);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display({"%0t: %s: expected byte=%02h pad=%0d final=%0b, ",
                "got byte=%02h pad=%0d final=%0b"},
               $realtime, what, exp_item.packed_byte, exp_item.pad_count,
               exp_item.final_byte, res.packed_byte, res.pad_count, res.final_byte);
  endtask

  // Compare result transactions, then predict from command transactions
  always @(posedge clk) begin
    pcbp_pkg::res_item_t exp_item;
    if (rst) begin
      leftover_bits  = '0;
      leftover_count = '0;
      fail_count     = 0;
      expected_bytes.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_bytes.size() == 0) begin
          note_failure("unexpected result", '0);
        end else begin
          exp_item = expected_bytes.pop_front();
          if (res.packed_byte !== exp_item.packed_byte ||
              res.pad_count   !== exp_item.pad_count ||
              res.final_byte  !== exp_item.final_byte)
            note_failure("result mismatch", exp_item);
        end
      end
      if (cmd_valid && cmd_ready) pack_code_bytes(cmd);
    end
    outstanding = expected_bytes.size();
  end

endmodule

[test/tb_prefix_code_bit_packer_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_prefix_code_bit_packer_unit
// Drives the prefix code bit packer with code loads, encodes and flushes:
// a short directed run over the corner cases, then random traffic with
// random idling on both channels, a long output hold-off and a full drain.
// Checking is done by packed_byte_checker.
// ============================================================================
module tb_prefix_code_bit_packer_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS     = 285;
  localparam int SINK_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES     = 20;

  logic                clk = 1'b0;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_ready;
  pcbp_pkg::cmd_item_t cmd;
  logic                res_valid;
  logic                res_ready;
  pcbp_pkg::res_item_t res;
  int                  fail_count;
  int                  outstanding;

  int         idle_pct      = 29;
  bit         sink_hold_req = 1'b0;
  bit         loaded [256];
  logic [7:0] loaded_syms [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prefix_code_bit_packer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  packed_byte_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Offer one command transaction; returns at the edge it is accepted
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] sym,
                          input logic [5:0] len, input logic [31:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= pcbp_pkg::cmd_item_t'{op, sym, len, val};
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  task automatic load_code(input logic [7:0] sym, input logic [5:0] len,
                           input logic [31:0] val);
    send_cmd(pcbp_pkg::OP_LOAD, sym, len, val);
    if (!loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  // Unused fields carry random noise
  task automatic encode_sym(input logic [7:0] sym);
    send_cmd(pcbp_pkg::OP_ENCODE, sym, 6'($urandom), $urandom);
  endtask

  task automatic send_noise_op(input logic [1:0] op);
    send_cmd(op, 8'($urandom), 6'($urandom), $urandom);
  endtask

  // Stop offering until every expected byte has come out
  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    res_ready <= 1'b0;
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        repeat (SINK_HOLD_CYCLES) begin
          res_ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        res_ready <= ($urandom_range(0, 99) >= idle_pct);
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int          pick;
    int          len_kind;
    logic [5:0]  len;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: flush with nothing pending, then table corners
    send_noise_op(pcbp_pkg::OP_FLUSH);
    load_code(8'd0,   6'd8,  32'h0000_00a5);
    load_code(8'd255, 6'd32, 32'hffff_ffff);
    load_code(8'd1,   6'd1,  32'h0000_0001);
    load_code(8'd2,   6'd63, 32'h1234_5678);   // long code, saturates
    load_code(8'd3,   6'd0,  32'hdead_beef);   // zero length
    load_code(8'd4,   6'd5,  32'hffff_ffe0);   // upper bits ignored
    load_code(8'd128, 6'd40, 32'h0000_0000);
    load_code(8'd5,   6'd33, 32'h8000_0001);
    encode_sym(8'd0);
    encode_sym(8'd1);
    encode_sym(8'd255);                        // 33 bits: four bytes
    encode_sym(8'd2);
    encode_sym(8'd3);
    encode_sym(8'd4);
    send_noise_op(pcbp_pkg::OP_FLUSH);
    send_noise_op(pcbp_pkg::OP_FLUSH);
    send_noise_op(OP_UNUSED);
    encode_sym(8'd128);
    encode_sym(8'd5);
    encode_sym(8'd1);
    encode_sym(8'd1);
    encode_sym(8'd1);
    send_noise_op(pcbp_pkg::OP_FLUSH);

    // Random traffic
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_pct = (i >= 60 && i < 120) ? 0 : 29;
      if (i == 150) wait_drained();
      if (i == 200) sink_hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        len_kind = $urandom_range(0, 9);
        if (len_kind == 0)      len = 6'd0;
        else if (len_kind == 1) len = 6'($urandom_range(33, 63));
        else if (len_kind == 2) len = 6'($urandom_range(17, 32));
        else                    len = 6'($urandom_range(1, 16));
        load_code(8'($urandom), len, $urandom);
      end else if (pick < 82) begin
        encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
      end else if (pick < 94) begin
        send_noise_op(pcbp_pkg::OP_FLUSH);
      end else begin
        send_noise_op(OP_UNUSED);
      end
    end
    send_noise_op(pcbp_pkg::OP_FLUSH);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
